// File: hw/rtl/multichannel_interpolating_fir_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel interpolating FIR
// Concurrent checks on a clock and an active-low synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_INTERPOLATING_FIR_TOP_MACROS_SVH
`define MULTICHANNEL_INTERPOLATING_FIR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MIFIR_ASSERT_SAME(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MIFIR_ASSERT_NEXT(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error(msg);

`endif

// File: hw/rtl/mifir_pkg.sv
// ----------------------------------------------------------------------------
// mifir_pkg
// Types and constants shared by the multichannel interpolating FIR.
// ----------------------------------------------------------------------------
package mifir_pkg;

    localparam int COLUMNS_DEF      = 32;
    localparam int TAPS_DEF         = 257;
    localparam int UPSAMPLE_DEF     = 4;
    localparam int SAMPLE_WIDTH     = 16;
    localparam int COEFF_WIDTH      = 16;
    localparam int COEF_INDEX_WIDTH = 9;
    localparam int PRODUCT_WIDTH    = SAMPLE_WIDTH + COEFF_WIDTH;
    localparam int OUT_WIDTH        = 48;
    localparam int COLUMN_WIDTH     = 5;
    localparam int PHASE_WIDTH      = 2;

    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                              kind;
        logic [COEF_INDEX_WIDTH-1:0]       coef_index;
        logic signed [COEFF_WIDTH-1:0]     coef_value;
        logic signed [SAMPLE_WIDTH-1:0]    sample_re;
        logic signed [SAMPLE_WIDTH-1:0]    sample_im;
        logic                              frame_end;
    } s_item_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] out_re;
        logic signed [OUT_WIDTH-1:0] out_im;
        logic [COLUMN_WIDTH-1:0]     column;
        logic [PHASE_WIDTH-1:0]      phase;
        logic                        run_last;
        logic                        stream_end;
    } m_item_t;

    typedef struct packed {
        logic clr_step;
        logic coef_write;
        logic latch_sample;
        logic mac_issue;
        logic mac_first;
        logic mac_last;
        logic out_load;
        logic tap_write;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic acc_done;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/multichannel_interpolating_fir_top.sv
// Samples are not overlapped: a new one is taken only after every phase result of the
//   last one has been loaded into the output register. The single complex-by-real MAC unit
//   walks every tap once per phase.
// Reset is synchronous and active low; afterwards a clearing pass that zeroes every
//   entry of the tap memory keeps s_ready low.
// ----------------------------------------------------------------------------
// multichannel_interpolating_fir_top
// Upsample-by-UPSAMPLE complex FIR with a separate tap history for every column.
// ----------------------------------------------------------------------------
`include "multichannel_interpolating_fir_top_macros.svh"

module multichannel_interpolating_fir_top import mifir_pkg::*; #(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int TAPS     = TAPS_DEF,
    parameter int UPSAMPLE = UPSAMPLE_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  s_item_t s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output m_item_t m_data
);

    // Widths of the column, tap index and phase counters.
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int IW = $clog2(TAPS);
    localparam int PW = (UPSAMPLE > 1) ? $clog2(UPSAMPLE) : 1;

    cmd_t          cmd;
    status_t       status;
    logic [IW-1:0] idx;
    logic [PW-1:0] phase;
    logic [CW-1:0] col;

    // The controller owns the sequencing: it sweeps the tap index for each
    // phase, waits for the MAC pipeline to drain, and hands the result over
    // once the output register is free. Every transaction on the input side
    // is taken only while the controller is idle.
    mifir_ctrl #(
        .COLUMNS (COLUMNS),
        .TAPS    (TAPS),
        .UPSAMPLE(UPSAMPLE),
        .CW      (CW),
        .IW      (IW),
        .PW      (PW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_kind     (s_data.kind),
        .s_frame_end(s_data.frame_end),
        .s_ready    (s_ready),
        .cmd        (cmd),
        .status     (status),
        .idx        (idx),
        .phase      (phase),
        .col        (col)
    );

    // The datapath holds the circular tap buffers of all columns in one
    // memory, the coefficient table in another, and a three-stage MAC
    // pipeline (read, multiply, accumulate). The result register decouples
    // the output side so that a new sample may be accepted while the last
    // result of the previous one still waits.
    mifir_dp #(
        .COLUMNS (COLUMNS),
        .TAPS    (TAPS),
        .UPSAMPLE(UPSAMPLE),
        .CW      (CW),
        .IW      (IW),
        .PW      (PW)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .status (status),
        .idx    (idx),
        .phase  (phase),
        .col    (col),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // A sample keeps the block busy, so the input closes straight after it.
    `MIFIR_ASSERT_NEXT(a_busy_after_sample, aclk, aresetn, s_valid && s_ready && s_data.kind, !s_ready, "input still ready after a sample")
    // The final result of a sample always carries the last phase.
    `MIFIR_ASSERT_SAME(a_last_phase, aclk, aresetn, m_valid && m_data.run_last, m_data.phase == PHASE_WIDTH'(UPSAMPLE - 1), "run_last on a wrong phase")
    // The frame end is only ever echoed on the final result of a sample.
    `MIFIR_ASSERT_SAME(a_end_on_last, aclk, aresetn, m_valid && m_data.stream_end, m_data.run_last, "stream_end without run_last")

endmodule

// File: hw/rtl/mifir_ram.sv
// ----------------------------------------------------------------------------
// mifir_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mifir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/mifir_ctrl.sv
// ----------------------------------------------------------------------------
// mifir_ctrl
// Sequencer: clearing pass, coefficient loads, tap sweeps and result hand-off.
// ----------------------------------------------------------------------------
module mifir_ctrl import mifir_pkg::*; #(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int TAPS     = TAPS_DEF,
    parameter int UPSAMPLE = UPSAMPLE_DEF,
    parameter int CW       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
    parameter int IW       = $clog2(TAPS),
    parameter int PW       = (UPSAMPLE > 1) ? $clog2(UPSAMPLE) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_kind,
    input  logic          s_frame_end,
    output logic          s_ready,
    output cmd_t          cmd,
    input  status_t       status,
    output logic [IW-1:0] idx,
    output logic [PW-1:0] phase,
    output logic [CW-1:0] col
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [CW-1:0] col_reg, col_next;
    logic          fe_reg, fe_next;
    logic          accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        col_next   = col_reg;
        fe_next    = fe_reg;
        cmd        = '0;
        cmd.mac_first = (idx_reg == '0);
        cmd.mac_last  = (idx_reg == IW'(TAPS - 1));
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_COEF) begin
                        cmd.coef_write = 1'b1;
                    end else begin
                        cmd.latch_sample = 1'b1;
                        fe_next    = s_frame_end;
                        idx_next   = '0;
                        phase_next = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                if (idx_reg == IW'(TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (status.acc_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.tap_write = 1'b1;
                    idx_next      = '0;
                    if (phase_reg == PW'(UPSAMPLE - 1)) begin
                        state_next = ST_IDLE;
                        if (fe_reg || col_reg == CW'(COLUMNS - 1)) begin
                            col_next = '0;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end else begin
                        phase_next = phase_reg + 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            phase_reg <= '0;
            col_reg   <= '0;
            fe_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            col_reg   <= col_next;
            fe_reg    <= fe_next;
        end
    end

    assign idx   = idx_reg;
    assign phase = phase_reg;
    assign col   = col_reg;

endmodule

// File: hw/rtl/mifir_dp.sv
// ----------------------------------------------------------------------------
// mifir_dp
// Tap and coefficient memories, complex-by-real MAC pipeline, result register.
// ----------------------------------------------------------------------------
module mifir_dp import mifir_pkg::*; #(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int TAPS     = TAPS_DEF,
    parameter int UPSAMPLE = UPSAMPLE_DEF,
    parameter int CW       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
    parameter int IW       = $clog2(TAPS),
    parameter int PW       = (UPSAMPLE > 1) ? $clog2(UPSAMPLE) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  s_item_t       s_data,
    input  cmd_t          cmd,
    output status_t       status,
    input  logic [IW-1:0] idx,
    input  logic [PW-1:0] phase,
    input  logic [CW-1:0] col,
    output logic          m_valid,
    input  logic          m_ready,
    output m_item_t       m_data
);

    localparam int HIST   = TAPS - 1;
    localparam int HW     = (HIST > 1) ? $clog2(HIST) : 1;
    localparam int TDEPTH = COLUMNS * HIST;
    localparam int AW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int TW     = 2 * SAMPLE_WIDTH;

    logic [HW-1:0] ptr_reg [COLUMNS];
    logic [HW-1:0] ptr_cur;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] base, tap_raddr, tap_waddr;
    logic [IW:0]   ptr_x, idx_x, off_x;
    logic          tap_we;
    logic [TW-1:0] tap_wdata, tap_rdata;
    logic [COEFF_WIDTH-1:0] coef_rdata;
    logic          coef_we;

    logic signed [SAMPLE_WIDTH-1:0] smp_re_reg, smp_im_reg, xk_re, xk_im;
    logic signed [SAMPLE_WIDTH-1:0] op_re, op_im;
    logic          fe_reg;
    logic          s1_v_reg, s1_first_reg, s1_last_reg;
    logic          s2_v_reg, s2_first_reg, s2_last_reg;
    logic signed [PRODUCT_WIDTH-1:0] p_re_reg, p_im_reg;
    logic signed [OUT_WIDTH-1:0] acc_re_reg, acc_im_reg;
    logic          acc_done_reg;
    logic          m_valid_reg;
    m_item_t       m_data_reg;

    assign ptr_cur = ptr_reg[col];
    assign base    = AW'(col * HIST);

    // Tap i-1 sits i places behind the write pointer, modulo the history depth.
    always_comb begin
        ptr_x = (IW + 1)'(ptr_cur);
        idx_x = (IW + 1)'(idx);
        if (ptr_x >= idx_x) begin
            off_x = ptr_x - idx_x;
        end else begin
            off_x = ptr_x + (IW + 1)'(HIST) - idx_x;
        end
    end

    assign tap_raddr = base + AW'(off_x);
    assign xk_re     = (phase == '0) ? smp_re_reg : '0;
    assign xk_im     = (phase == '0) ? smp_im_reg : '0;
    assign tap_we    = cmd.clr_step || cmd.tap_write;
    assign tap_waddr = cmd.clr_step ? clr_cnt_reg : base + AW'(ptr_cur);
    assign tap_wdata = cmd.clr_step ? '0 : {xk_re, xk_im};
    assign coef_we   = cmd.coef_write && (32'(s_data.coef_index) < 32'(TAPS));

    mifir_ram #(.WIDTH(TW), .DEPTH(TDEPTH), .AW(AW)) u_tap_ram (
        .clk   (aclk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (tap_wdata),
        .raddr (tap_raddr),
        .rdata (tap_rdata)
    );

    mifir_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(TAPS), .AW(IW)) u_coef_ram (
        .clk   (aclk),
        .we    (coef_we),
        .waddr (IW'(s_data.coef_index)),
        .wdata (s_data.coef_value),
        .raddr (idx),
        .rdata (coef_rdata)
    );

    // Slot zero multiplies the entering value rather than a stored tap.
    assign op_re = s1_first_reg ? xk_re : $signed(tap_rdata[TW-1:SAMPLE_WIDTH]);
    assign op_im = s1_first_reg ? xk_im : $signed(tap_rdata[SAMPLE_WIDTH-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.latch_sample) begin
            smp_re_reg <= s_data.sample_re;
            smp_im_reg <= s_data.sample_im;
            fe_reg     <= s_data.frame_end;
        end
        p_re_reg <= op_re * $signed(coef_rdata);
        p_im_reg <= op_im * $signed(coef_rdata);
        if (s2_v_reg) begin
            if (s2_first_reg) begin
                acc_re_reg <= OUT_WIDTH'(p_re_reg);
                acc_im_reg <= OUT_WIDTH'(p_im_reg);
            end else begin
                acc_re_reg <= acc_re_reg + OUT_WIDTH'(p_re_reg);
                acc_im_reg <= acc_im_reg + OUT_WIDTH'(p_im_reg);
            end
        end
        if (cmd.out_load) begin
            m_data_reg.out_re     <= acc_re_reg;
            m_data_reg.out_im     <= acc_im_reg;
            m_data_reg.column     <= COLUMN_WIDTH'(col);
            m_data_reg.phase      <= PHASE_WIDTH'(phase);
            m_data_reg.run_last   <= (phase == PW'(UPSAMPLE - 1));
            m_data_reg.stream_end <= (phase == PW'(UPSAMPLE - 1)) && fe_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            s1_v_reg     <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_v_reg     <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            acc_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int c = 0; c < COLUMNS; c++) begin
                ptr_reg[c] <= '0;
            end
        end else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            s1_v_reg     <= cmd.mac_issue;
            s1_first_reg <= cmd.mac_issue && cmd.mac_first;
            s1_last_reg  <= cmd.mac_issue && cmd.mac_last;
            s2_v_reg     <= s1_v_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            acc_done_reg <= s2_v_reg && s2_last_reg;
            if (cmd.tap_write) begin
                ptr_reg[col] <= (ptr_cur == HW'(HIST - 1)) ? '0 : ptr_cur + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clr_last = cmd.clr_step && (clr_cnt_reg == AW'(TDEPTH - 1));
    assign status.acc_done = acc_done_reg;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multichannel interpolating FIR
// Loads the coefficient table and then sends complex samples with random
// gaps on both sides. An in-bench filter model works out the four phase
// outputs of every sample, and each output transaction is checked field by
// field against them.
// ----------------------------------------------------------------------------
module tb;
    import mifir_pkg::*;

    localparam int NCOL = COLUMNS_DEF;
    localparam int NTAP = TAPS_DEF;
    localparam int NUP  = UPSAMPLE_DEF;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    s_item_t s_data;
    logic    m_valid;
    logic    m_ready;
    m_item_t m_data;

    // Filter state as the bench sees it: one tap line per column.
    logic signed [SAMPLE_WIDTH-1:0] hist_re [NCOL][NTAP-1];
    logic signed [SAMPLE_WIDTH-1:0] hist_im [NCOL][NTAP-1];
    logic signed [COEFF_WIDTH-1:0]  coef_tab [NTAP];
    int unsigned                    col_now;

    m_item_t pending_outputs[$];
    int      error_count;
    // When set, neither side inserts any idle cycles.
    bit      no_gaps;

    multichannel_interpolating_fir_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Generous ceiling: the slowest correct run is well under a third of this,
    // including the clearing pass that follows reset.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report(input string what, input longint want, input longint got);
        error_count++;
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // Applies one accepted transaction to the bench's filter state and queues
    // the outputs it must produce.
    task automatic predict_filter(input s_item_t it);
        longint  acc_re;
        longint  acc_im;
        m_item_t res;
        logic signed [SAMPLE_WIDTH-1:0] xr;
        logic signed [SAMPLE_WIDTH-1:0] xi;
        if (it.kind == KIND_COEF) begin
            // Slots beyond the table are ignored.
            if (it.coef_index < NTAP)
                coef_tab[it.coef_index] = it.coef_value;
            return;
        end
        for (int k = 0; k < NUP; k++) begin
            // Only phase zero carries the real sample; the rest are stuffed zeros.
            xr = (k == 0) ? it.sample_re : '0;
            xi = (k == 0) ? it.sample_im : '0;
            acc_re = longint'(xr) * longint'(coef_tab[0]);
            acc_im = longint'(xi) * longint'(coef_tab[0]);
            for (int i = 1; i < NTAP; i++) begin
                acc_re += longint'(hist_re[col_now][i-1]) * longint'(coef_tab[i]);
                acc_im += longint'(hist_im[col_now][i-1]) * longint'(coef_tab[i]);
            end
            for (int i = NTAP - 2; i > 0; i--) begin
                hist_re[col_now][i] = hist_re[col_now][i-1];
                hist_im[col_now][i] = hist_im[col_now][i-1];
            end
            hist_re[col_now][0] = xr;
            hist_im[col_now][0] = xi;
            res.out_re     = acc_re[OUT_WIDTH-1:0];
            res.out_im     = acc_im[OUT_WIDTH-1:0];
            res.column     = col_now[COLUMN_WIDTH-1:0];
            res.phase      = k[PHASE_WIDTH-1:0];
            res.run_last   = (k == NUP - 1);
            res.stream_end = (k == NUP - 1) ? it.frame_end : 1'b0;
            pending_outputs.push_back(res);
        end
        // A frame end restarts the row at column zero.
        col_now = it.frame_end ? 0 : (col_now + 1) % NCOL;
    endtask

    // Presents one transaction, after a random gap, and holds it until accepted.
    task automatic send_item(input s_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_filter(it);
    endtask

    function automatic s_item_t coef_item(input int idx, input int val);
        s_item_t it;
        it            = s_item_t'({$urandom, $urandom});
        it.kind       = KIND_COEF;
        it.coef_index = idx[COEF_INDEX_WIDTH-1:0];
        it.coef_value = val[COEFF_WIDTH-1:0];
        return it;
    endfunction

    function automatic s_item_t sample_item(input int re, input int im, input bit fend);
        s_item_t it;
        it           = s_item_t'({$urandom, $urandom});
        it.kind      = KIND_SAMPLE;
        it.sample_re = re[SAMPLE_WIDTH-1:0];
        it.sample_im = im[SAMPLE_WIDTH-1:0];
        it.frame_end = fend;
        return it;
    endfunction

    function automatic int rand_word();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return $signed($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Output side: random back-pressure, then a check against the oldest expectation.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (pending_outputs.size() == 0) begin
                report("unexpected transaction", 0, 1);
            end else begin
                m_item_t want;
                want = pending_outputs.pop_front();
                if (m_data.out_re !== want.out_re)
                    report("out_re", want.out_re, m_data.out_re);
                if (m_data.out_im !== want.out_im)
                    report("out_im", want.out_im, m_data.out_im);
                if (m_data.column !== want.column)
                    report("column", want.column, m_data.column);
                if (m_data.phase !== want.phase)
                    report("phase", want.phase, m_data.phase);
                if (m_data.run_last !== want.run_last)
                    report("run_last", want.run_last, m_data.run_last);
                if (m_data.stream_end !== want.stream_end)
                    report("stream_end", want.stream_end, m_data.stream_end);
            end
        end
    end

    // Every slot is written before the first sample, since an unwritten slot
    // has no defined value. The first and last slots take the extremes.
    task automatic test_load_coefficients();
        send_item(coef_item(0, 32767));
        for (int i = 1; i < NTAP - 1; i++)
            send_item(coef_item(i, rand_word()));
        send_item(coef_item(NTAP - 1, -32768));
    endtask

    // Extreme samples, a frame end part-way through a row and a plain zero sample.
    task automatic test_directed_samples();
        send_item(sample_item(32767, -32768, 1'b0));
        send_item(sample_item(-32768, 32767, 1'b0));
        send_item(sample_item(-32768, -32768, 1'b0));
        send_item(sample_item(32767, 32767, 1'b1));
        send_item(sample_item(0, 0, 1'b0));
        send_item(sample_item(-1, 1, 1'b0));
        send_item(sample_item(32767, -32768, 1'b1));
    endtask

    // Writes past the end of the table must leave it untouched.
    task automatic test_table_bounds();
        send_item(coef_item(NTAP, 12345));
        send_item(coef_item(511, -32768));
        send_item(coef_item(NTAP - 1, 32767));
        send_item(sample_item(1000, -1000, 1'b0));
        send_item(coef_item(NTAP + 3, 32767));
        send_item(sample_item(-32768, 32767, 1'b0));
    endtask

    // Mostly samples, with a few coefficient rewrites (some out of range) and
    // the odd frame end, so columns wrap and restart. Stretches without gaps
    // alternate with stretches of random idling on both sides.
    task automatic test_random_mix();
        for (int n = 0; n < 200; n++) begin
            if (n % 40 == 0)
                no_gaps = ~no_gaps;
            if ($urandom_range(0, 99) < 15)
                send_item(coef_item($urandom_range(0, 511), rand_word()));
            else
                send_item(sample_item(rand_word(), rand_word(), $urandom_range(0, 29) == 0));
        end
    endtask

    initial begin
        error_count = 0;
        no_gaps     = 1'b1;
        col_now     = 0;
        for (int c = 0; c < NCOL; c++) begin
            for (int i = 0; i < NTAP - 1; i++) begin
                hist_re[c][i] = '0;
                hist_im[c][i] = '0;
            end
        end
        for (int i = 0; i < NTAP; i++)
            coef_tab[i] = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        no_gaps = 1'b0;
        test_load_coefficients();
        test_directed_samples();
        test_table_bounds();
        test_random_mix();
        s_valid <= 1'b0;

        // Drain, then allow roughly one sample's processing time for strays.
        wait (pending_outputs.size() == 0);
        repeat (1100) @(posedge aclk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
